### sv/crlf_line_buffer_ring_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CR-LF line buffer ring checkers
// ----------------------------------------------------------------------------
`ifndef CRLF_LINE_BUFFER_RING_ASSERT_SVH
`define CRLF_LINE_BUFFER_RING_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define CLBR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CLBR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/clbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clbr_pkg
// Shared types and constants of the CR-LF line buffer ring.
// ----------------------------------------------------------------------------
package clbr_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int NUM_SLOTS_DEF  = 4;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_TAKE = 1'b1;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       line_ready;
        logic [7:0] line_byte;
        logic [5:0] byte_position;
        logic [6:0] line_length;
        logic       last;
        logic       overflow;
    } t_out_item;

    typedef struct packed {
        logic byte_wr;
        logic take_start;
        logic rd_issue;
        logic emit_byte;
        logic emit_single;
        logic release_slot;
        logic pos_inc;
    } t_ctrl_cmd;

    typedef struct packed {
        logic cur_ready;
        logic len_zero;
        logic last_pos;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

### sv/clbr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clbr_ctrl
// Sequencer: accepts words, steps a take through the line read-out.
// ----------------------------------------------------------------------------
module clbr_ctrl
    import clbr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_opcode,
    input  wire t_dp_status i_status,
    output logic            o_in_stall,
    output t_ctrl_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;
    localparam logic [1:0] S_SINGLE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_BYTE) begin
                        o_cmd.byte_wr = 1'b1;
                    end else begin
                        o_cmd.take_start = 1'b1;
                        n_state = (i_status.cur_ready && !i_status.len_zero) ? S_READ
                                                                            : S_SINGLE;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_status.last_pos) begin
                        o_cmd.release_slot = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        o_cmd.pos_inc = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            S_SINGLE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_single  = 1'b1;
                    o_cmd.release_slot = i_status.cur_ready;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

### sv/clbr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clbr_datapath
// Line store, per-slot fill counts and ready marks, output register.
// ----------------------------------------------------------------------------
module clbr_datapath
    import clbr_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_ctrl_cmd  i_cmd,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_out_stall,
    output t_dp_status      o_status,
    output logic            o_out_valid,
    output t_out_item       o_out_item
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(LINE_BYTES + 1);
    localparam int PW = $clog2(LINE_BYTES);
    localparam int AW = $clog2(NUM_SLOTS * LINE_BYTES);
    localparam int DEPTH = NUM_SLOTS * LINE_BYTES;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_fill [NUM_SLOTS];
    logic          r_ready [NUM_SLOTS];
    logic [SW-1:0] r_wslot;
    logic [SW-1:0] r_rslot;
    logic          r_prev_cr;
    logic          r_dropped;
    logic          r_ovf;
    logic [PW-1:0] r_pos;
    logic          r_out_valid;
    t_out_item     r_out_item;

    logic          closes;
    logic          is_cr;
    logic          slot_busy;
    logic          slot_full;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] rd_len;
    logic          out_free;

    function automatic logic [SW-1:0] f_next(input logic [SW-1:0] s);
        f_next = (s == SW'(NUM_SLOTS - 1)) ? '0 : s + SW'(1);
    endfunction

    assign is_cr     = (i_rx_byte == BYTE_CR);
    assign closes    = (i_rx_byte == BYTE_LF) && r_prev_cr;
    assign slot_busy = r_ready[r_wslot];
    assign slot_full = (r_fill[r_wslot] == CW'(LINE_BYTES));
    assign wr_en     = i_cmd.byte_wr && !slot_busy && !slot_full;
    assign wr_addr   = AW'(r_wslot) * AW'(LINE_BYTES) + AW'(r_fill[r_wslot][PW-1:0]);
    assign rd_addr   = AW'(r_rslot) * AW'(LINE_BYTES) + AW'(r_pos);
    assign rd_len    = r_fill[r_rslot];
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_status.cur_ready = r_ready[r_rslot];
    assign o_status.len_zero  = (rd_len == '0);
    assign o_status.last_pos  = ((CW'(r_pos) + CW'(1)) == rd_len);
    assign o_status.out_free  = out_free;

    // Line store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_fill[i]  <= '0;
                r_ready[i] <= 1'b0;
            end
            r_wslot   <= '0;
            r_rslot   <= '0;
            r_prev_cr <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            if (i_cmd.byte_wr) begin
                if (slot_busy) begin
                    r_dropped <= 1'b1;
                    r_prev_cr <= closes ? 1'b0 : is_cr;
                end else begin
                    if (!slot_full) begin
                        r_fill[r_wslot] <= r_fill[r_wslot] + CW'(1);
                    end else begin
                        r_dropped <= 1'b1;
                    end
                    if (closes) begin
                        r_ready[r_wslot] <= 1'b1;
                        r_wslot          <= f_next(r_wslot);
                        r_prev_cr        <= 1'b0;
                    end else begin
                        r_prev_cr <= is_cr;
                    end
                end
            end
            if (i_cmd.take_start) begin
                r_dropped <= 1'b0;
            end
            if (i_cmd.release_slot) begin
                r_ready[r_rslot] <= 1'b0;
                r_fill[r_rslot]  <= '0;
                r_rslot          <= f_next(r_rslot);
            end
        end
    end

    // Take context: overflow snapshot and read position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_start) begin
            r_ovf <= r_dropped;
            r_pos <= '0;
        end else if (i_cmd.pos_inc) begin
            r_pos <= r_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_byte || i_cmd.emit_single) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_byte) begin
            r_out_item.line_ready    <= 1'b1;
            r_out_item.line_byte     <= r_rd_data;
            r_out_item.byte_position <= 6'(r_pos);
            r_out_item.line_length   <= 7'(rd_len);
            r_out_item.last          <= o_status.last_pos;
            r_out_item.overflow      <= r_ovf;
        end else if (i_cmd.emit_single) begin
            r_out_item.line_ready    <= o_status.cur_ready;
            r_out_item.line_byte     <= '0;
            r_out_item.byte_position <= '0;
            r_out_item.line_length   <= '0;
            r_out_item.last          <= 1'b1;
            r_out_item.overflow      <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

### sv/crlf_line_buffer_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_line_buffer_ring
// Ring of CR-LF terminated receive line buffers with take-line read-out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall  | t_in_item  (opcode, rx_byte)
//  out     | output    | o_out_valid / i_out_stall| t_out_item (one line byte/result)
//
//  After a received byte the next word is accepted in the next cycle.
//  A take of a ready line is accepted first; then each byte is read from the
//  registered line store and loaded into the output register. A take with no
//  ready line, or of an empty ready line, loads a single result word.
//  The input stalls from an accepted take until its last result is loaded;
//  output stalls stretch the take by holding the output register.
//  Reset is synchronous; the line store needs no clearing pass after reset.
//
module crlf_line_buffer_ring
    import clbr_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    // Commands from the sequencer, status back from the datapath.
    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Sequencer: accept words when idle, walk a take byte by byte.
    clbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_item.opcode),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Datapath: line store, slot bookkeeping, CR-LF detect, output register.
    clbr_datapath #(
        .LINE_BYTES (LINE_BYTES),
        .NUM_SLOTS  (NUM_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rx_byte   (i_in_item.rx_byte),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

### sv/clbr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clbr_checker
// Port-level checks of the CR-LF line buffer ring, bound to the top level.
// ----------------------------------------------------------------------------
`include "crlf_line_buffer_ring_assert.svh"

module clbr_checker
    import clbr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // Hold a stalled output word.
    `CLBR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item), "stalled output word changed")

    // Drop output valid after reset.
    `CLBR_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // A not-ready result is a single zero word marked last.
    `CLBR_ASSERT(a_not_ready, i_clk, i_rst_n, o_out_valid && !o_out_item.line_ready |-> o_out_item.last && o_out_item.line_byte == 8'd0 && o_out_item.byte_position == 6'd0 && o_out_item.line_length == 7'd0, "bad not-ready result")

    // Stall the input once a take is accepted.
    `CLBR_ASSERT(a_take_stall, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_item.opcode == OP_TAKE |=> o_in_stall, "input not stalled during take")

endmodule

bind crlf_line_buffer_ring clbr_checker u_checker (.*);
`default_nettype wire

### test/crlf_line_buffer_ring_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crlf_line_buffer_ring_check
// Watches both channels of the line buffer ring, predicts every output word
// from the accepted input words and compares them field by field.
// ----------------------------------------------------------------------------
module crlf_line_buffer_ring_check
    import clbr_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_words_pending
);

    // Shadow of the ring
    logic [7:0]  line_mem [NUM_SLOTS][LINE_BYTES];
    int unsigned slot_fill [NUM_SLOTS];
    bit          slot_closed [NUM_SLOTS];
    int unsigned wr_slot;
    int unsigned rd_slot;
    bit          cr_seen;
    bit          drop_flag;

    t_out_item   expected_words [$];
    int          mismatch_total;

    assign o_fail_count = mismatch_total;

    initial begin
        mismatch_total  = 0;
        wr_slot         = 0;
        rd_slot         = 0;
        cr_seen         = 1'b0;
        drop_flag       = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_fill[s]   = 0;
            slot_closed[s] = 1'b0;
        end
    end

    function automatic int unsigned ring_next(input int unsigned s);
        return (s + 1 >= NUM_SLOTS) ? 0 : s + 1;
    endfunction

    task automatic absorb_rx_byte(input logic [7:0] b);
        bit ends_line;
        ends_line = (b == BYTE_LF) && cr_seen;
        if (slot_closed[wr_slot]) begin
            // slot not yet released: drop, only track CR
            drop_flag = 1'b1;
            cr_seen   = ends_line ? 1'b0 : (b == BYTE_CR);
        end else begin
            if (slot_fill[wr_slot] < LINE_BYTES) begin
                line_mem[wr_slot][slot_fill[wr_slot]] = b;
                slot_fill[wr_slot] += 1;
            end else begin
                drop_flag = 1'b1;
            end
            if (ends_line) begin
                slot_closed[wr_slot] = 1'b1;
                wr_slot              = ring_next(wr_slot);
                cr_seen              = 1'b0;
            end else begin
                cr_seen = (b == BYTE_CR);
            end
        end
    endtask

    task automatic predict_take();
        t_out_item   w;
        int unsigned n;
        w          = '0;
        w.overflow = drop_flag;
        drop_flag  = 1'b0;
        if (!slot_closed[rd_slot]) begin
            w.last = 1'b1;
            expected_words.push_back(w);
        end else begin
            n = (slot_fill[rd_slot] > LINE_BYTES) ? LINE_BYTES : slot_fill[rd_slot];
            w.line_ready = 1'b1;
            if (n == 0) begin
                w.last = 1'b1;
                expected_words.push_back(w);
            end else begin
                for (int i = 0; i < n; i++) begin
                    w.line_byte     = line_mem[rd_slot][i];
                    w.byte_position = 6'(i);
                    w.line_length   = 7'(n);
                    w.last          = (i == n - 1);
                    expected_words.push_back(w);
                end
            end
            slot_closed[rd_slot] = 1'b0;
            slot_fill[rd_slot]   = 0;
            rd_slot              = ring_next(rd_slot);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            mismatch_total++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        end
    endtask

    task automatic check_word(input t_out_item got);
        t_out_item exp_w;
        if (expected_words.size() == 0) begin
            mismatch_total++;
            $display("%0t: unexpected output word, expected none, actual %h", $time, got);
        end else begin
            exp_w = expected_words.pop_front();
            check_field("line_ready", 8'(exp_w.line_ready), 8'(got.line_ready));
            check_field("line_byte", exp_w.line_byte, got.line_byte);
            check_field("byte_position", 8'(exp_w.byte_position), 8'(got.byte_position));
            check_field("line_length", 8'(exp_w.line_length), 8'(got.line_length));
            check_field("last", 8'(exp_w.last), 8'(got.last));
            check_field("overflow", 8'(exp_w.overflow), 8'(got.overflow));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall)
                check_word(i_out_item);
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.opcode == OP_BYTE)
                    absorb_rx_byte(i_in_item.rx_byte);
                else
                    predict_take();
            end
        end
        o_words_pending <= expected_words.size();
    end

endmodule

### test/crlf_line_buffer_ring_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crlf_line_buffer_ring_test
// Drives received bytes and take commands into the line buffer ring with
// random gaps and output stalls; the checker beside the block predicts and
// compares every output word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module crlf_line_buffer_ring_test;
    import clbr_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int ITEM_TARGET  = 380;
    localparam int HOLD_CYCLES  = 240;   // long receiver hold-off
    localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    int        fail_count;
    int        words_pending;
    int        items_sent = 0;
    int        idle_cycles = 0;
    bit        hold_req = 1'b0;   // ask the receiver for a long hold-off
    bit        burst_mode = 1'b0; // sender offers back to back while set

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    crlf_line_buffer_ring u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    crlf_line_buffer_ring_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (out_item),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    // Mostly short gaps, zero often enough to give back-to-back stretches,
    // and now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one word and hold it until accepted. Valid stays high into the
    // next word when no gap follows, so it is never lowered and raised in
    // the same step.
    task automatic send_word(input t_in_item w);
        int unsigned gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic push_rx_byte(input logic [7:0] b);
        t_in_item w;
        w.opcode  = OP_BYTE;
        w.rx_byte = b;
        send_word(w);
    endtask

    // The byte field of a take is ignored by the block; fill it anyway.
    task automatic request_line(input logic [7:0] junk);
        t_in_item w;
        w.opcode  = OP_TAKE;
        w.rx_byte = junk;
        send_word(w);
    endtask

    // Body of random bytes with the odd CR mixed in, closed by CR LF.
    task automatic send_crlf_line(input int unsigned body_len);
        for (int i = 0; i < body_len; i++) begin
            if ($urandom_range(0, 15) == 0)
                push_rx_byte(BYTE_CR);
            else
                push_rx_byte(8'($urandom_range(0, 255)));
        end
        push_rx_byte(BYTE_CR);
        push_rx_byte(BYTE_LF);
    endtask

    function automatic int unsigned pick_body_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 8);
        else if (r < 95)
            return $urandom_range(9, 40);
        else
            return $urandom_range(60, 70);   // can run past the slot capacity
    endfunction

    // Stray words between lines: lone LF, lone CR, random byte, extra take.
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: push_rx_byte(BYTE_LF);
            1: push_rx_byte(BYTE_CR);
            2: push_rx_byte(8'($urandom_range(0, 255)));
            default: request_line(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin
        int unsigned n_lines;
        int unsigned n_takes;

        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n  <= 1'b1;

        // --- directed part ---
        request_line(8'hFF);                 // take on an empty ring
        push_rx_byte(8'h00);                 // byte extremes, then CR LF
        push_rx_byte(8'hFF);
        push_rx_byte(BYTE_CR);
        push_rx_byte(BYTE_LF);
        push_rx_byte(BYTE_LF);               // LF right after a close: no pair
        push_rx_byte(BYTE_CR);               // CR CR LF: only the last pair closes
        push_rx_byte(BYTE_CR);
        push_rx_byte(BYTE_LF);
        request_line(8'h00);
        request_line(8'h5A);
        request_line(8'hA5);                 // nothing ready
        push_rx_byte(BYTE_CR);
        request_line(8'h00);                 // take between CR and LF
        push_rx_byte(BYTE_LF);
        push_rx_byte(8'h55);
        push_rx_byte(8'hAA);
        push_rx_byte(BYTE_CR);
        push_rx_byte(BYTE_LF);
        request_line(8'hFF);
        request_line(8'h00);

        // --- pressure round ---
        // Overfill one slot, then write more lines than the ring holds so
        // bytes land on unreleased slots. Then hold the receiver off while
        // takes keep coming, so the block backs up and stalls its input.
        send_crlf_line(70);
        for (int i = 0; i < 5; i++)
            send_crlf_line($urandom_range(0, 6));
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++)
            request_line(8'($urandom_range(0, 255)));

        // --- random rounds ---
        // A round writes a few lines, at times more than the ring holds,
        // then takes about as many back, sometimes more.
        while (items_sent < ITEM_TARGET) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            n_lines    = $urandom_range(1, 6);
            for (int i = 0; i < n_lines; i++) begin
                if ($urandom_range(0, 5) == 0)
                    send_noise();
                send_crlf_line(pick_body_len());
            end
            n_takes = $urandom_range(0, n_lines + 1);
            for (int i = 0; i < n_takes; i++)
                request_line(8'($urandom_range(0, 255)));
        end
        burst_mode = 1'b0;

        // Drain whatever lines are still stored.
        for (int i = 0; i < NUM_SLOTS_DEF + 1; i++)
            request_line(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        // Let the pending count catch up with the last take, then wait out
        // the rest of the words and a few cycles more for strays.
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side: alternate runs of taking words with random stalls, and
    // serve one long hold-off when asked.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall_len;

        out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(30, 60)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                stall_len = pick_gap();
                if (stall_len != 0) begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no word moves on either side for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### crlf_line_buffer_ring.f
+incdir+sv
sv/clbr_pkg.sv
sv/clbr_ctrl.sv
sv/clbr_datapath.sv
sv/crlf_line_buffer_ring.sv
sv/clbr_checker.sv
test/crlf_line_buffer_ring_check.sv
test/crlf_line_buffer_ring_test.sv
